// ----- design/per_domain_port_event_counter_top_defines.svh -----
// assertion helpers for the per-domain port event counter
`ifndef PER_DOMAIN_PORT_EVENT_COUNTER_TOP_DEFINES_SVH
`define PER_DOMAIN_PORT_EVENT_COUNTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PDPEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdpec: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PDPEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdpec: next-cycle check failed");

`endif

// ----- design/pdpec_pkg.sv -----
package pdpec_pkg;

   // table geometry
   localparam int DOMAIN_SLOTS     = 32;
   localparam int PORTS_PER_DOMAIN = 16;

   // field widths
   localparam int DOM_IN_W = 15;
   localparam int PORT_W   = 17;
   localparam int COUNT_W  = 32;
   localparam int SLOT_OUT_W = 4;

   // derived widths
   localparam int DOM_W   = $clog2(DOMAIN_SLOTS);
   localparam int FILL_W  = $clog2(PORTS_PER_DOMAIN + 1);
   localparam int PADDR_W = $clog2(DOMAIN_SLOTS * PORTS_PER_DOMAIN);
   localparam int PDATA_W = COUNT_W + PORT_W;
   localparam int DDATA_W = COUNT_W + FILL_W;

   // special domain id, folded onto the last slot
   localparam logic [DOM_IN_W-1:0] SPECIAL_DOMAIN = 15'h7fff;

   typedef enum logic [1:0] {
      ST_EXISTING = 2'd0,
      ST_ADDED    = 2'd1,
      ST_FULL     = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DOM,
      S_SCAN,
      S_DECIDE,
      S_EMIT
   } state_type;

   // saturating increment of a count
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
   endfunction

endpackage

// ----- design/pdpec_ram.sv -----
module pdpec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/per_domain_port_event_counter_top.sv -----
// per-domain port event counter
// req channel: one trace item per handshake, domain id and port number in
// tdata. rsp channel: one result item per request, status in tuser, slot,
// port count and domain total in tdata.
// the port table (keys and counts) and the domain table (fill and total)
// each live in a synchronous ram with a registered read port; an item is
// handled by a read-modify-write sequencer, one item at a time.
// after acceptance an item reads its domain entry, then scans the port
// slots of its domain (up to the matching slot on a hit, up to the domain
// fill on a miss), then on a miss appends or drops the port in a decide
// step, and then loads its result; the scan reads one key per cycle from
// the port ram. an out-of-range domain goes straight to the result load.
// the next item is taken the cycle after the load.
// reset is synchronous and clears the domain valid bits, so every domain
// reads as empty right after reset; the port ram needs no clearing since
// only slots below a domain's fill are read.
// the result sits in an output register; while the receiver stalls the
// next item is still accepted and worked on, and only its final load waits
// for the output register to free up.
`include "per_domain_port_event_counter_top_defines.svh"

module per_domain_port_event_counter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [14:0] domain_id, [31:15] port_number
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] slot_index, [35:4] port_count, [67:36] domain_total, [71:68] zero
   output logic [71:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser
);

   localparam int DOM_W   = pdpec_pkg::DOM_W;
   localparam int FILL_W  = pdpec_pkg::FILL_W;
   localparam int PADDR_W = pdpec_pkg::PADDR_W;
   localparam int COUNT_W = pdpec_pkg::COUNT_W;
   localparam int PORT_W  = pdpec_pkg::PORT_W;

   pdpec_pkg::state_type state_ff, state_in;

   // control state
   logic [pdpec_pkg::DOMAIN_SLOTS-1:0] dvalid_ff, dvalid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FILL_W-1:0]    idx_ff, idx_in;

   // item payload
   logic [DOM_W-1:0]     dom_ff, dom_in;
   logic [PORT_W-1:0]    port_ff, port_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [COUNT_W-1:0]   total_ff, total_in;

   // pending result
   pdpec_pkg::status_type res_status_ff, res_status_in;
   logic [pdpec_pkg::SLOT_OUT_W-1:0] res_slot_ff, res_slot_in;
   logic [COUNT_W-1:0]   res_count_ff, res_count_in;
   logic [COUNT_W-1:0]   res_total_ff, res_total_in;

   // output register
   pdpec_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [pdpec_pkg::SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [COUNT_W-1:0]   rsp_total_ff, rsp_total_in;

   // ram ports
   logic                           p_wr_en;
   logic [PADDR_W-1:0]             p_wr_addr, p_rd_addr;
   logic [pdpec_pkg::PDATA_W-1:0]  p_wr_data, p_rd_data;
   logic                           d_wr_en;
   logic [DOM_W-1:0]               d_wr_addr, d_rd_addr;
   logic [pdpec_pkg::DDATA_W-1:0]  d_wr_data, d_rd_data;

   // decoded helpers
   logic [pdpec_pkg::DOM_IN_W-1:0] req_dom;
   logic [PORT_W-1:0]  req_port;
   logic               req_special;
   logic               req_in_range;
   logic [DOM_W-1:0]   req_slot;
   logic               accept;
   logic               out_free;
   logic [PADDR_W-1:0] base_c;
   logic [FILL_W-1:0]  raw_fill_c, fill_c;
   logic [COUNT_W-1:0] raw_total_c;
   logic               hit_c;
   logic [COUNT_W-1:0] hit_count_c;
   logic               last_slot_c;
   logic               table_full_c;

   // port table: {count, key}
   pdpec_ram #(
      .WIDTH(pdpec_pkg::PDATA_W),
      .DEPTH(pdpec_pkg::DOMAIN_SLOTS * pdpec_pkg::PORTS_PER_DOMAIN)
   ) u_port_ram (
      .clock  (clock),
      .wr_en  (p_wr_en),
      .wr_addr(p_wr_addr),
      .wr_data(p_wr_data),
      .rd_addr(p_rd_addr),
      .rd_data(p_rd_data)
   );

   // domain table: {total, fill}
   pdpec_ram #(
      .WIDTH(pdpec_pkg::DDATA_W),
      .DEPTH(pdpec_pkg::DOMAIN_SLOTS)
   ) u_dom_ram (
      .clock  (clock),
      .wr_en  (d_wr_en),
      .wr_addr(d_wr_addr),
      .wr_data(d_wr_data),
      .rd_addr(d_rd_addr),
      .rd_data(d_rd_data)
   );

   // input decode
   assign req_dom      = req_tdata[14:0];
   assign req_port     = req_tdata[31:15];
   assign req_special  = (req_dom == pdpec_pkg::SPECIAL_DOMAIN);
   assign req_in_range = req_special ||
                         (req_dom < pdpec_pkg::DOM_IN_W'(pdpec_pkg::DOMAIN_SLOTS));
   assign req_slot     = req_special ? DOM_W'(pdpec_pkg::DOMAIN_SLOTS - 1)
                                     : req_dom[DOM_W-1:0];

   assign req_tready = (state_ff == pdpec_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // domain table read, empty when never written since reset
   assign base_c      = PADDR_W'(dom_ff) * PADDR_W'(pdpec_pkg::PORTS_PER_DOMAIN);
   assign raw_fill_c  = dvalid_ff[dom_ff] ? d_rd_data[FILL_W-1:0] : '0;
   assign raw_total_c = dvalid_ff[dom_ff] ? d_rd_data[FILL_W +: COUNT_W] : '0;
   assign fill_c      = (raw_fill_c > FILL_W'(pdpec_pkg::PORTS_PER_DOMAIN))
                        ? FILL_W'(pdpec_pkg::PORTS_PER_DOMAIN) : raw_fill_c;

   // scan compare on the key read last cycle
   assign hit_c        = (p_rd_data[PORT_W-1:0] == port_ff);
   assign hit_count_c  = pdpec_pkg::sat_inc(p_rd_data[PORT_W +: COUNT_W]);
   assign last_slot_c  = ((idx_ff + FILL_W'(1)) >= fill_ff);
   assign table_full_c = (fill_ff >= FILL_W'(pdpec_pkg::PORTS_PER_DOMAIN));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pdpec_pkg::S_IDLE: begin
            if (accept) begin
               state_in = req_in_range ? pdpec_pkg::S_DOM : pdpec_pkg::S_EMIT;
            end
         end
         pdpec_pkg::S_DOM: begin
            state_in = (fill_c == '0) ? pdpec_pkg::S_DECIDE : pdpec_pkg::S_SCAN;
         end
         pdpec_pkg::S_SCAN: begin
            if (hit_c) begin
               state_in = pdpec_pkg::S_EMIT;
            end else if (last_slot_c) begin
               state_in = pdpec_pkg::S_DECIDE;
            end
         end
         pdpec_pkg::S_DECIDE: begin
            state_in = pdpec_pkg::S_EMIT;
         end
         pdpec_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = pdpec_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pdpec_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and ram controls
   always_comb begin
      dvalid_in     = dvalid_ff;
      idx_in        = idx_ff;
      dom_in        = dom_ff;
      port_in       = port_ff;
      fill_in       = fill_ff;
      total_in      = total_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_count_in  = res_count_ff;
      res_total_in  = res_total_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      p_wr_en   = 1'b0;
      p_wr_addr = base_c + PADDR_W'(idx_ff);
      p_wr_data = {hit_count_c, port_ff};
      p_rd_addr = base_c + PADDR_W'(idx_ff) + PADDR_W'(1);
      d_wr_en   = 1'b0;
      d_wr_addr = dom_ff;
      d_wr_data = {total_ff, fill_ff};
      d_rd_addr = req_slot;

      unique case (state_ff)
         pdpec_pkg::S_IDLE: begin
            if (accept) begin
               dom_in        = req_slot;
               port_in       = req_port;
               res_status_in = pdpec_pkg::ST_RANGE;
               res_slot_in   = '0;
               res_count_in  = '0;
               res_total_in  = '0;
            end
         end
         pdpec_pkg::S_DOM: begin
            // first key read, domain total counted up front
            fill_in   = fill_c;
            total_in  = pdpec_pkg::sat_inc(raw_total_c);
            idx_in    = '0;
            p_rd_addr = base_c;
         end
         pdpec_pkg::S_SCAN: begin
            if (hit_c) begin
               // known port: bump its count in place
               p_wr_en       = 1'b1;
               d_wr_en       = 1'b1;
               dvalid_in[dom_ff] = 1'b1;
               res_status_in = pdpec_pkg::ST_EXISTING;
               res_slot_in   = pdpec_pkg::SLOT_OUT_W'(idx_ff);
               res_count_in  = hit_count_c;
               res_total_in  = total_ff;
            end else begin
               idx_in = idx_ff + FILL_W'(1);
            end
         end
         pdpec_pkg::S_DECIDE: begin
            d_wr_en           = 1'b1;
            dvalid_in[dom_ff] = 1'b1;
            res_total_in      = total_ff;
            if (table_full_c) begin
               // port dropped, only the total moves
               res_status_in = pdpec_pkg::ST_FULL;
               res_slot_in   = '0;
               res_count_in  = '0;
            end else begin
               // append the port with a count of one
               p_wr_en       = 1'b1;
               p_wr_addr     = base_c + PADDR_W'(fill_ff);
               p_wr_data     = {COUNT_W'(1), port_ff};
               d_wr_data     = {total_ff, fill_ff + FILL_W'(1)};
               res_status_in = pdpec_pkg::ST_ADDED;
               res_slot_in   = pdpec_pkg::SLOT_OUT_W'(fill_ff);
               res_count_in  = COUNT_W'(1);
            end
         end
         pdpec_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_count_in  = res_count_ff;
               rsp_total_in  = res_total_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdpec_pkg::S_IDLE;
         dvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dom_ff        <= dom_in;
      port_ff       <= port_in;
      fill_ff       <= fill_in;
      total_ff      <= total_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_count_ff  <= res_count_in;
      res_total_ff  <= res_total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0000, rsp_total_ff, rsp_count_ff, rsp_slot_ff};

   // an accepted item always leaves idle
   `PDPEC_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept,
      state_ff != pdpec_pkg::S_IDLE)

   // the scan never runs past the domain fill
   `PDPEC_ASSERT_NOW(a_scan_below_fill, clock, reset, state_ff == pdpec_pkg::S_SCAN,
      idx_ff < fill_ff)

   // table writes only come from the scan hit or the decide step
   `PDPEC_ASSERT_NOW(a_write_states, clock, reset, d_wr_en,
      (state_ff == pdpec_pkg::S_SCAN) || (state_ff == pdpec_pkg::S_DECIDE))

   // a free output register takes the pending result
   `PDPEC_ASSERT_NEXT(a_emit_loads, clock, reset,
      (state_ff == pdpec_pkg::S_EMIT) && out_free, rsp_tvalid)

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

   localparam int DOMAIN_SLOTS     = pdpec_pkg::DOMAIN_SLOTS;
   localparam int PORTS_PER_DOMAIN = pdpec_pkg::PORTS_PER_DOMAIN;
   localparam int DOM_IN_W         = pdpec_pkg::DOM_IN_W;
   localparam int PORT_W           = pdpec_pkg::PORT_W;
   localparam int COUNT_W          = pdpec_pkg::COUNT_W;
   localparam int SLOT_OUT_W       = pdpec_pkg::SLOT_OUT_W;
   localparam logic [DOM_IN_W-1:0] SPECIAL_DOMAIN = pdpec_pkg::SPECIAL_DOMAIN;

   localparam int TABLE_DEPTH   = DOMAIN_SLOTS * PORTS_PER_DOMAIN;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int PORT_POOL_LEN = 20;

   typedef struct packed {
      pdpec_pkg::status_type  status;
      logic [SLOT_OUT_W-1:0]  slot;
      logic [COUNT_W-1:0]     port_count;
      logic [COUNT_W-1:0]     domain_total;
   } port_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [14:0] domain_id, [31:15] port_number
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [3:0] slot_index, [35:4] port_count, [67:36] domain_total, [71:68] zero
   logic [71:0] rsp_tdata;
   // [1:0] status
   logic [1:0]  rsp_tuser;

   // predicted copy of the block's tables
   logic [PORT_W-1:0]  key_table   [TABLE_DEPTH];
   logic [COUNT_W-1:0] hits_table  [TABLE_DEPTH];
   int unsigned        fill_table  [DOMAIN_SLOTS];
   logic [COUNT_W-1:0] total_table [DOMAIN_SLOTS];

   port_result_type    pending_results[$];
   logic [PORT_W-1:0]  port_pool[PORT_POOL_LEN];
   int                 error_count = 0;
   int                 stall_cycles = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;

   per_domain_port_event_counter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // saturating count step
   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
      return (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   // predict the result of one event and update the tables
   function automatic port_result_type count_event(input logic [DOM_IN_W-1:0] dom_in,
                                                   input logic [PORT_W-1:0] port);
      port_result_type r;
      int unsigned     dom;
      int unsigned     fill;
      int unsigned     base;
      int unsigned     i;
      r.status       = pdpec_pkg::ST_RANGE;
      r.slot         = '0;
      r.port_count   = '0;
      r.domain_total = '0;
      if (dom_in == SPECIAL_DOMAIN) begin
         dom = DOMAIN_SLOTS - 1;
      end else if (dom_in < DOMAIN_SLOTS) begin
         dom = 32'(dom_in);
      end else begin
         return r;
      end
      fill = (fill_table[dom] > PORTS_PER_DOMAIN) ? PORTS_PER_DOMAIN : fill_table[dom];
      base = dom * PORTS_PER_DOMAIN;
      total_table[dom] = bump(total_table[dom]);
      r.domain_total = total_table[dom];
      // search the ports seen so far, in insertion order
      for (i = 0; i < fill; i++) begin
         if (key_table[base + i] == port) begin
            hits_table[base + i] = bump(hits_table[base + i]);
            r.status     = pdpec_pkg::ST_EXISTING;
            r.slot       = i[SLOT_OUT_W-1:0];
            r.port_count = hits_table[base + i];
            return r;
         end
      end
      if (fill >= PORTS_PER_DOMAIN) begin
         r.status = pdpec_pkg::ST_FULL;
         return r;
      end
      key_table[base + fill]  = port;
      hits_table[base + fill] = COUNT_W'(1);
      fill_table[dom]         = fill + 1;
      r.status     = pdpec_pkg::ST_ADDED;
      r.slot       = fill[SLOT_OUT_W-1:0];
      r.port_count = COUNT_W'(1);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] exp_val);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got,
               exp_val);
      error_count++;
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // compare each result item, then predict each accepted request item
   always @(posedge clock) begin
      port_result_type exp_r;
      if (reset) begin
         for (int d = 0; d < DOMAIN_SLOTS; d++) begin
            fill_table[d]  = 0;
            total_table[d] = '0;
         end
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata[63:0], '0);
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_tuser != exp_r.status)
                  report_mismatch("status", 64'(rsp_tuser), 64'(exp_r.status));
               if (rsp_tdata[3:0] != exp_r.slot)
                  report_mismatch("slot_index", 64'(rsp_tdata[3:0]), 64'(exp_r.slot));
               if (rsp_tdata[35:4] != exp_r.port_count)
                  report_mismatch("port_count", 64'(rsp_tdata[35:4]),
                                  64'(exp_r.port_count));
               if (rsp_tdata[67:36] != exp_r.domain_total)
                  report_mismatch("domain_total", 64'(rsp_tdata[67:36]),
                                  64'(exp_r.domain_total));
               if (rsp_tdata[71:68] != 4'd0)
                  report_mismatch("tdata padding", 64'(rsp_tdata[71:68]), '0);
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(count_event(req_tdata[14:0], req_tdata[31:15]));
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // send one event, with random idle cycles ahead of it
   task automatic send_event(input logic [DOM_IN_W-1:0] dom, input logic [PORT_W-1:0] port);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {port, dom};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // lowest and highest in-range ids and ports, plus a repeat hit
   task automatic test_field_extremes();
      send_event(15'd0, 17'd0);
      send_event(15'd0, 17'h1ffff);
      send_event(15'd0, 17'd0);
      send_event(15'd31, 17'h1ffff);
      send_event(15'd31, 17'h0aaaa);
   endtask

   // the special id shares the last domain slot
   task automatic test_special_domain();
      send_event(SPECIAL_DOMAIN, 17'h1ffff);
      send_event(SPECIAL_DOMAIN, 17'h15555);
      send_event(15'd31, 17'h15555);
   endtask

   // ids past the table leave the state alone
   task automatic test_domain_range();
      send_event(15'd32, 17'd1);
      send_event(15'h7ffe, 17'h1ffff);
      send_event(15'h4000, 17'd0);
   endtask

   // fill one domain, then overflow it and hit its last slot
   task automatic test_table_full();
      for (int i = 0; i < PORTS_PER_DOMAIN; i++)
         send_event(15'd7, PORT_W'(17'h100 + i));
      send_event(15'd7, 17'h1f000);
      send_event(15'd7, PORT_W'(17'h100 + PORTS_PER_DOMAIN - 1));
   endtask

   // hot domains favoured, ports mostly drawn from a small pool, so tables fill up
   task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
      logic [DOM_IN_W-1:0] dom;
      logic [PORT_W-1:0]   port;
      int                  pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            dom = DOM_IN_W'($urandom_range(0, 3));
         else if (pick < 72)
            dom = DOM_IN_W'($urandom_range(0, DOMAIN_SLOTS - 1));
         else if (pick < 82)
            dom = SPECIAL_DOMAIN;
         else
            dom = DOM_IN_W'($urandom_range(DOMAIN_SLOTS, 15'h7ffe));
         if ($urandom_range(0, 99) < 85)
            port = port_pool[$urandom_range(0, PORT_POOL_LEN - 1)];
         else
            port = PORT_W'($urandom_range(0, 17'h1ffff));
         send_event(dom, port);
      end
   endtask

   initial begin
      for (int i = 0; i < PORT_POOL_LEN; i++)
         port_pool[i] = PORT_W'($urandom_range(0, 17'h1ffff));
      port_pool[0] = 17'd0;
      port_pool[1] = 17'h1ffff;
      send_idle_pct = 25;
      recv_idle_pct = 55;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_special_domain();
      test_domain_range();
      test_table_full();
      test_random_traffic(200, 25, 55);
      test_random_traffic(200, 55, 25);
      test_random_traffic(200, 0, 0);
      req_tvalid <= 1'b0;

      // drain outstanding results
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
